// File: hdl/fcc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Formation consensus controller package
// Shared widths, request and register codes, and the control bundle that
// steers the shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
package fcc_pkg;

    // Gains are signed Q8.8.
    localparam int GAIN_W = 16;
    // Widest second operand: the derivative difference times 400.
    localparam int OPB_W  = 27;
    localparam int PROD_W = GAIN_W + OPB_W;
    // Accumulator of one axis in Q8.8 units.
    localparam int ACC_W  = 48;

    // Request kinds carried in tuser.
    localparam logic [1:0] REQ_TICK = 2'd0;
    localparam logic [1:0] REQ_MSG  = 2'd1;
    localparam logic [1:0] REQ_CTRL = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] REG_KP_X     = 3'd0;
    localparam logic [2:0] REG_KP_Y     = 3'd1;
    localparam logic [2:0] REG_KD_X     = 3'd2;
    localparam logic [2:0] REG_KD_Y     = 3'd3;
    localparam logic [2:0] REG_KI_GAIN  = 3'd4;
    localparam logic [2:0] REG_SILENCE  = 3'd5;
    localparam logic [2:0] REG_NBR_ADDR = 3'd6;
    localparam logic [2:0] REG_ACC_CODE = 3'd7;

    typedef struct packed {
        logic clear;   // zero the accumulator
        logic mul;     // start a product this cycle
    } t_mac_ctl;

endpackage

// File: hdl/fcc_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared multiply-accumulate unit
// One signed multiplier with a registered product that feeds an accumulator
// in the following cycle.
// ----------------------------------------------------------------------------
module fcc_mac (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  fcc_pkg::t_mac_ctl                   i_ctl,
    input  logic signed [fcc_pkg::GAIN_W-1:0]   i_opa,
    input  logic signed [fcc_pkg::OPB_W-1:0]    i_opb,
    output logic signed [fcc_pkg::ACC_W-1:0]    o_acc,
    output logic                                o_prod_vld
);

    logic signed [fcc_pkg::PROD_W-1:0] r_prod;
    logic                              r_prod_vld;
    logic signed [fcc_pkg::ACC_W-1:0]  r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
            r_acc      <= '0;
        end else begin
            r_prod_vld <= i_ctl.mul;
            if (i_ctl.clear) begin
                r_acc <= '0;
            end else if (r_prod_vld) begin
                r_acc <= r_acc + fcc_pkg::ACC_W'(r_prod);
            end
        end
        r_prod <= i_opa * i_opb;
    end

    assign o_acc      = r_acc;
    assign o_prod_vld = r_prod_vld;

endmodule

// File: hdl/formation_consensus_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Formation consensus controller
// PD position control for one vehicle plus a consensus term built from the
// error offsets of up to four neighbors, with neighbor aging.
// ----------------------------------------------------------------------------
// Usage:
// Items enter on the slave stream; tuser carries the request kind (tick,
// received message, control step) and tdata the message and own-state fields.
// Only a control step yields an item on the master stream, carrying both
// saturated corrections and both saturated velocity commands.
// The block handles one item at a time and drops tready while it works.
// A tick walks the neighbor slots one per cycle, and a message searches the
// slots one per cycle. A control step sums the active offsets slot by slot,
// then runs six products through the single shared multiplier (three per
// axis, each axis followed by a drain state and a rounding state), then
// loads the result register in its push state: the result appears in the
// same cycle that tready returns. The slot walk and the shared multiplier
// set how long a control step takes.
// A finished result sits in an output register; while the receiver stalls,
// the block still accepts ticks and messages, and a later control step waits
// in its final cycle until the register frees up.
// Reset clears the neighbor activity, the stored previous errors, the
// configuration registers (silence limit returns to 100) and output tvalid.
// Configuration is written through a plain write port; the user must write it
// only while the block is idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module formation_consensus_controller #(
    parameter int NEIGHBOR_SLOTS = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // Slave stream
    input  logic          i_s_axis_tvalid,
    output logic          o_s_axis_tready,
    // tdata from bit 0: msg_src[15:0], msg_code[23:16], msg_err_x[39:24],
    // msg_err_y[55:40], own_err_x[71:56], own_err_y[87:72],
    // speed_set_x[103:88], speed_set_y[119:104]
    input  logic [119:0]  i_s_axis_tdata,
    // tuser from bit 0: req_type[1:0]
    input  logic [1:0]    i_s_axis_tuser,
    // Master stream
    output logic          o_m_axis_tvalid,
    input  logic          i_m_axis_tready,
    // tdata from bit 0: ctrl_x[15:0], ctrl_y[31:16], vel_cmd_x[47:32],
    // vel_cmd_y[63:48]
    output logic [63:0]   o_m_axis_tdata,
    // Configuration write port
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_addr,
    input  logic [63:0]   i_cfg_data
);

    localparam int SLOT_W = (NEIGHBOR_SLOTS > 1) ? $clog2(NEIGHBOR_SLOTS) : 1;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NEIGHBOR_SLOTS - 1);
    // The sum of the active offsets grows by one bit per doubling of slots.
    localparam int SUM_W = 17 + SLOT_W;
    // Rounded correction width and one more bit for the setpoint sum.
    localparam int CORR_W = fcc_pkg::ACC_W - 8;
    localparam int VSUM_W = CORR_W + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TICK,
        S_MSG,
        S_SUM,
        S_MUL,
        S_DRAIN,
        S_FIN,
        S_PUSH
    } t_state;

    // Configuration registers.
    logic signed [15:0] r_kp_x, r_kp_y, r_kd_x, r_kd_y, r_ki_gain;
    logic [14:0]        r_silence_limit;
    logic [63:0]        r_nbr_addrs;
    logic [7:0]         r_acc_code;

    // Neighbor table.
    logic signed [16:0] r_off_x [NEIGHBOR_SLOTS];
    logic signed [16:0] r_off_y [NEIGHBOR_SLOTS];
    logic [15:0]        r_timer [NEIGHBOR_SLOTS];
    logic [NEIGHBOR_SLOTS-1:0] r_active;

    // Controller state and latched item.
    t_state             r_state;
    logic [SLOT_W-1:0]  r_slot;
    logic [1:0]         r_step;
    logic               r_axis;
    logic signed [16:0] r_prev_x, r_prev_y;
    logic [15:0]        r_src;
    logic [7:0]         r_code;
    logic signed [16:0] r_new_off_x, r_new_off_y;
    logic signed [16:0] r_ex, r_ey;
    logic signed [15:0] r_sp_x, r_sp_y;
    logic signed [SUM_W-1:0] r_sum_x, r_sum_y;
    logic signed [fcc_pkg::OPB_W-1:0] r_dx400, r_dy400;
    logic signed [15:0] r_ctrl_x, r_ctrl_y, r_vel_x, r_vel_y;
    logic               r_out_vld;
    logic [63:0]        r_out_data;

    logic [15:0]        w_slot_addr [NEIGHBOR_SLOTS];
    logic signed [17:0] w_dx, w_dy;
    logic [15:0]        w_timer_inc;

    fcc_pkg::t_mac_ctl                  w_mac_ctl;
    logic signed [fcc_pkg::GAIN_W-1:0]  w_opa;
    logic signed [fcc_pkg::OPB_W-1:0]   w_opb;
    logic signed [fcc_pkg::ACC_W-1:0]   w_acc;
    logic                               w_prod_vld;
    logic signed [fcc_pkg::ACC_W-1:0]   w_rnd;
    logic signed [CORR_W-1:0]           w_corr;
    logic signed [VSUM_W-1:0]           w_vsum;
    logic signed [15:0]                 w_ctrl_sat, w_vel_sat;

    // Clamp a wide signed value to the 16-bit range.
    function automatic logic signed [15:0] sat16(input logic signed [VSUM_W-1:0] v);
        logic signed [15:0] res;
        if (v > VSUM_W'(32767)) begin
            res = 16'sh7FFF;
        end else if (v < -VSUM_W'(32768)) begin
            res = 16'sh8000;
        end else begin
            res = v[15:0];
        end
        return res;
    endfunction

    for (genvar g = 0; g < NEIGHBOR_SLOTS; g++) begin : g_addr
        assign w_slot_addr[g] = r_nbr_addrs[16*g +: 16];
    end

    // Derivative differences; times 400 is done as 256 + 128 + 16.
    assign w_dx = 18'(r_ex) - 18'(r_prev_x);
    assign w_dy = 18'(r_ey) - 18'(r_prev_y);

    assign w_timer_inc = r_timer[r_slot] + 16'd1;

    // Operand selection for the shared multiplier: kp*e, kd*d*400, ki*sum.
    always_comb begin
        w_opa = r_ki_gain;
        w_opb = fcc_pkg::OPB_W'(r_axis ? r_sum_y : r_sum_x);
        case (r_step)
            2'd0: begin
                w_opa = r_axis ? r_kp_y : r_kp_x;
                w_opb = fcc_pkg::OPB_W'(r_axis ? r_ey : r_ex);
            end
            2'd1: begin
                w_opa = r_axis ? r_kd_y : r_kd_x;
                w_opb = r_axis ? r_dy400 : r_dx400;
            end
            default: begin
                w_opa = r_ki_gain;
                w_opb = fcc_pkg::OPB_W'(r_axis ? r_sum_y : r_sum_x);
            end
        endcase
    end

    assign w_mac_ctl.clear = (r_state == S_FIN);
    assign w_mac_ctl.mul   = (r_state == S_MUL);

    fcc_mac u_mac (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_mac_ctl),
        .i_opa      (w_opa),
        .i_opb      (w_opb),
        .o_acc      (w_acc),
        .o_prod_vld (w_prod_vld)
    );

    // Round half up to whole units: an arithmetic shift floors.
    assign w_rnd      = w_acc + fcc_pkg::ACC_W'(128);
    assign w_corr     = w_rnd[fcc_pkg::ACC_W-1:8];
    assign w_vsum     = VSUM_W'(r_axis ? r_sp_y : r_sp_x) + VSUM_W'(w_corr);
    assign w_ctrl_sat = sat16(VSUM_W'(w_corr));
    assign w_vel_sat  = sat16(w_vsum);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_slot          <= '0;
            r_step          <= '0;
            r_axis          <= 1'b0;
            r_active        <= '0;
            r_prev_x        <= '0;
            r_prev_y        <= '0;
            r_out_vld       <= 1'b0;
            r_kp_x          <= '0;
            r_kp_y          <= '0;
            r_kd_x          <= '0;
            r_kd_y          <= '0;
            r_ki_gain       <= '0;
            r_silence_limit <= 15'd100;
            r_nbr_addrs     <= '0;
            r_acc_code      <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    fcc_pkg::REG_KP_X:     r_kp_x          <= i_cfg_data[15:0];
                    fcc_pkg::REG_KP_Y:     r_kp_y          <= i_cfg_data[15:0];
                    fcc_pkg::REG_KD_X:     r_kd_x          <= i_cfg_data[15:0];
                    fcc_pkg::REG_KD_Y:     r_kd_y          <= i_cfg_data[15:0];
                    fcc_pkg::REG_KI_GAIN:  r_ki_gain       <= i_cfg_data[15:0];
                    fcc_pkg::REG_SILENCE:  r_silence_limit <= i_cfg_data[14:0];
                    fcc_pkg::REG_NBR_ADDR: r_nbr_addrs     <= i_cfg_data;
                    fcc_pkg::REG_ACC_CODE: r_acc_code      <= i_cfg_data[7:0];
                    default: ;
                endcase
            end

            // The push cycle reloads the register itself when it frees up.
            if (r_out_vld && i_m_axis_tready && r_state != S_PUSH) begin
                r_out_vld <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    r_slot <= '0;
                    if (i_s_axis_tvalid) begin
                        r_src       <= i_s_axis_tdata[15:0];
                        r_code      <= i_s_axis_tdata[23:16];
                        r_new_off_x <= 17'($signed(i_s_axis_tdata[39:24]))
                                     - 17'($signed(i_s_axis_tdata[71:56]));
                        r_new_off_y <= 17'($signed(i_s_axis_tdata[55:40]))
                                     - 17'($signed(i_s_axis_tdata[87:72]));
                        r_ex        <= -17'($signed(i_s_axis_tdata[71:56]));
                        r_ey        <= -17'($signed(i_s_axis_tdata[87:72]));
                        r_sp_x      <= i_s_axis_tdata[103:88];
                        r_sp_y      <= i_s_axis_tdata[119:104];
                        r_sum_x     <= '0;
                        r_sum_y     <= '0;
                        case (i_s_axis_tuser)
                            fcc_pkg::REQ_TICK: r_state <= S_TICK;
                            fcc_pkg::REQ_MSG:  r_state <= S_MSG;
                            fcc_pkg::REQ_CTRL: r_state <= S_SUM;
                            default:           r_state <= S_IDLE;
                        endcase
                    end
                end

                S_TICK: begin
                    // Age one active slot per cycle; drop it past the limit.
                    if (r_active[r_slot]) begin
                        r_timer[r_slot] <= w_timer_inc;
                        if (w_timer_inc > {1'b0, r_silence_limit}) begin
                            r_active[r_slot] <= 1'b0;
                        end
                    end
                    if (r_slot == LAST_SLOT) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_slot <= r_slot + 1'b1;
                    end
                end

                S_MSG: begin
                    // The lowest slot with a matching address decides; a
                    // wrong code ends the search without an update.
                    if (w_slot_addr[r_slot] == r_src) begin
                        if (r_code == r_acc_code) begin
                            r_off_x[r_slot]  <= r_new_off_x;
                            r_off_y[r_slot]  <= r_new_off_y;
                            r_timer[r_slot]  <= '0;
                            r_active[r_slot] <= 1'b1;
                        end
                        r_state <= S_IDLE;
                    end else if (r_slot == LAST_SLOT) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_slot <= r_slot + 1'b1;
                    end
                end

                S_SUM: begin
                    if (r_active[r_slot]) begin
                        r_sum_x <= r_sum_x + SUM_W'(r_off_x[r_slot]);
                        r_sum_y <= r_sum_y + SUM_W'(r_off_y[r_slot]);
                    end
                    r_dx400 <= (fcc_pkg::OPB_W'(w_dx) <<< 8)
                             + (fcc_pkg::OPB_W'(w_dx) <<< 7)
                             + (fcc_pkg::OPB_W'(w_dx) <<< 4);
                    r_dy400 <= (fcc_pkg::OPB_W'(w_dy) <<< 8)
                             + (fcc_pkg::OPB_W'(w_dy) <<< 7)
                             + (fcc_pkg::OPB_W'(w_dy) <<< 4);
                    r_step <= '0;
                    r_axis <= 1'b0;
                    if (r_slot == LAST_SLOT) begin
                        r_state <= S_MUL;
                    end else begin
                        r_slot <= r_slot + 1'b1;
                    end
                end

                S_MUL: begin
                    if (r_step == 2'd2) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_step <= r_step + 2'd1;
                    end
                end

                S_DRAIN: begin
                    // The last product of the axis lands in the accumulator.
                    r_state <= S_FIN;
                end

                S_FIN: begin
                    r_step <= '0;
                    if (r_axis) begin
                        r_ctrl_y <= w_ctrl_sat;
                        r_vel_y  <= w_vel_sat;
                        r_state  <= S_PUSH;
                    end else begin
                        r_ctrl_x <= w_ctrl_sat;
                        r_vel_x  <= w_vel_sat;
                        r_axis   <= 1'b1;
                        r_state  <= S_MUL;
                    end
                end

                S_PUSH: begin
                    if (!r_out_vld || i_m_axis_tready) begin
                        r_out_data <= {r_vel_y, r_vel_x, r_ctrl_y, r_ctrl_x};
                        r_out_vld  <= 1'b1;
                        r_prev_x   <= r_ex;
                        r_prev_y   <= r_ey;
                        r_state    <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out_data;

    // The slot walk never leaves the table.
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot <= LAST_SLOT)
        else $error("slot counter beyond last neighbor slot");

    // A new result only appears out of the final control cycle.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(r_state) == S_PUSH)
        else $error("result loaded outside the push cycle");

    // Rounding reads a settled accumulator: no product is still in flight.
    a_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FIN |-> !w_prod_vld)
        else $error("accumulator rounded with a product pending");

    // Every product step is followed by another step or by the drain cycle.
    a_mul_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_MUL |=> (r_state == S_MUL || r_state == S_DRAIN))
        else $error("multiply sequence broken");

endmodule
